FILE: sv/dlc_pkg.sv
// ----------------------------------------------------------------------------
// dlc_pkg: shared types and constants for the card and PIN door lock core
// Mode, command and event codes, register indexes, register set and result
// structures, and the expected-key lookup for the PIN compare.
// ----------------------------------------------------------------------------
package dlc_pkg;

  // keys collected per PIN attempt
  localparam int unsigned PIN_DIGITS = 4;
  localparam int unsigned KCNT_W     = $clog2(PIN_DIGITS + 1);
  localparam int unsigned KIDX_W     = (PIN_DIGITS > 1) ? $clog2(PIN_DIGITS) : 1;

  localparam int unsigned TICK_W   = 25;
  localparam int unsigned LIMIT_W  = 24;
  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  localparam int unsigned CARD_W   = 40;
  localparam int unsigned KEY_W    = 8;
  localparam int unsigned PIN_W    = 32;
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned MODE_W   = 3;
  localparam int unsigned EV_W     = 3;
  localparam int unsigned FAIL_W   = 4;
  localparam int unsigned DIGITS_W = 3;
  localparam int unsigned RETRY_W  = 4;

  localparam logic [FAIL_W-1:0] FAIL_MAX = '1;

  // channel and port widths
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned IN_USER_W  = CMD_W;
  localparam int unsigned OUT_DATA_W = 24;
  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 40;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TICK    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_CARD    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_KEY     = 3'd2;
  localparam logic [CMD_W-1:0] CMD_OPEN    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLOSE   = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOCKOUT = 3'd5;
  localparam logic [CMD_W-1:0] CMD_STATUS  = 3'd6;

  // modes
  localparam logic [MODE_W-1:0] M_WAIT = 3'd0;
  localparam logic [MODE_W-1:0] M_PIN  = 3'd1;
  localparam logic [MODE_W-1:0] M_OPEN = 3'd2;
  localparam logic [MODE_W-1:0] M_DENY = 3'd3;
  localparam logic [MODE_W-1:0] M_LOCK = 3'd4;

  // event codes
  localparam logic [EV_W-1:0] EV_NONE     = 3'd0;
  localparam logic [EV_W-1:0] EV_CARD_OK  = 3'd1;
  localparam logic [EV_W-1:0] EV_CARD_BAD = 3'd2;
  localparam logic [EV_W-1:0] EV_PIN_OK   = 3'd3;
  localparam logic [EV_W-1:0] EV_PIN_BAD  = 3'd4;
  localparam logic [EV_W-1:0] EV_LOCKOUT  = 3'd5;
  localparam logic [EV_W-1:0] EV_TIMED    = 3'd6;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PIN_CODE    = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_CARD_ID     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_RETRIES = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_PIN_TIMEOUT = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_UNLOCK      = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_DENY        = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_LOCKOUT     = 3'd6;

  // register reset values
  localparam logic [PIN_W-1:0]   RST_PIN_CODE    = 32'd825373492;   // "1234"
  localparam logic [CARD_W-1:0]  RST_CARD_ID     = 40'd112247144651;
  localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 4'd3;
  localparam logic [LIMIT_W-1:0] RST_PIN_TIMEOUT = 24'd15000;
  localparam logic [LIMIT_W-1:0] RST_UNLOCK      = 24'd5000;
  localparam logic [LIMIT_W-1:0] RST_DENY        = 24'd3000;
  localparam logic [LIMIT_W-1:0] RST_LOCKOUT     = 24'd30000;

  typedef struct packed {
    logic [PIN_W-1:0]   pin_code;
    logic [CARD_W-1:0]  card_id;
    logic [RETRY_W-1:0] max_retries;
    logic [LIMIT_W-1:0] pin_timeout_ticks;
    logic [LIMIT_W-1:0] unlock_ticks;
    logic [LIMIT_W-1:0] deny_ticks;
    logic [LIMIT_W-1:0] lockout_ticks;
  } cfg_t;

  typedef struct packed {
    logic [EV_W-1:0]     event_res;
    logic [FAIL_W-1:0]   failure_count;
    logic [DIGITS_W-1:0] digits_entered;
    logic                led_blue;
    logic                led_green;
    logic                led_red;
    logic                door_open;
    logic [MODE_W-1:0]   mode;
  } res_t;

  localparam int unsigned RES_W = $bits(res_t);

  // expected byte for key position idx; positions beyond the code word want zero
  function automatic logic [KEY_W-1:0] exp_key(input logic [PIN_W-1:0] pin,
                                               input int unsigned idx);
    int unsigned pos;
    logic [KEY_W-1:0] want;
    pos  = PIN_DIGITS - 1 - idx;
    want = '0;
    if (pos < (PIN_W / KEY_W)) begin
      want = pin[KEY_W*pos +: KEY_W];
    end
    return want;
  endfunction

endpackage

FILE: sv/dlc_cfg.sv
// ----------------------------------------------------------------------------
// dlc_cfg: configuration register bank
// Seven write-only registers, loaded from the plain write port.
// ----------------------------------------------------------------------------
module dlc_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dlc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output dlc_pkg::cfg_t                  cfg
);

  dlc_pkg::cfg_t cfg_r;
  dlc_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_addr)
        dlc_pkg::REG_PIN_CODE:    cfg_nxt.pin_code = cfg_wdata[dlc_pkg::PIN_W-1:0];
        dlc_pkg::REG_CARD_ID:     cfg_nxt.card_id = cfg_wdata[dlc_pkg::CARD_W-1:0];
        dlc_pkg::REG_MAX_RETRIES: cfg_nxt.max_retries = cfg_wdata[dlc_pkg::RETRY_W-1:0];
        dlc_pkg::REG_PIN_TIMEOUT: begin
          cfg_nxt.pin_timeout_ticks = cfg_wdata[dlc_pkg::LIMIT_W-1:0];
        end
        dlc_pkg::REG_UNLOCK:      cfg_nxt.unlock_ticks = cfg_wdata[dlc_pkg::LIMIT_W-1:0];
        dlc_pkg::REG_DENY:        cfg_nxt.deny_ticks = cfg_wdata[dlc_pkg::LIMIT_W-1:0];
        dlc_pkg::REG_LOCKOUT:     cfg_nxt.lockout_ticks = cfg_wdata[dlc_pkg::LIMIT_W-1:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pin_code          <= dlc_pkg::RST_PIN_CODE;
      cfg_r.card_id           <= dlc_pkg::RST_CARD_ID;
      cfg_r.max_retries       <= dlc_pkg::RST_MAX_RETRIES;
      cfg_r.pin_timeout_ticks <= dlc_pkg::RST_PIN_TIMEOUT;
      cfg_r.unlock_ticks      <= dlc_pkg::RST_UNLOCK;
      cfg_r.deny_ticks        <= dlc_pkg::RST_DENY;
      cfg_r.lockout_ticks     <= dlc_pkg::RST_LOCKOUT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: sv/dlc_fsm.sv
// ----------------------------------------------------------------------------
// dlc_fsm: lock state and next-state logic
// Holds mode, collected keys, failure count and tick counter; computes the
// new state and the result for one request in a single pass.
// ----------------------------------------------------------------------------
module dlc_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic [dlc_pkg::CMD_W-1:0]    cmd,
  input  logic [dlc_pkg::CARD_W-1:0]   card_value,
  input  logic [dlc_pkg::KEY_W-1:0]    key_code,
  input  dlc_pkg::cfg_t                cfg,
  output dlc_pkg::res_t                res
);

  logic [dlc_pkg::MODE_W-1:0]  mode_r, mode_nxt;
  logic [dlc_pkg::KEY_W-1:0]   keys_r   [dlc_pkg::PIN_DIGITS];
  logic [dlc_pkg::KEY_W-1:0]   keys_nxt [dlc_pkg::PIN_DIGITS];
  logic [dlc_pkg::KEY_W-1:0]   keys_wr  [dlc_pkg::PIN_DIGITS];
  logic [dlc_pkg::KCNT_W-1:0]  kcnt_r, kcnt_nxt;
  logic [dlc_pkg::FAIL_W-1:0]  fail_r, fail_nxt;
  logic [dlc_pkg::TICK_W-1:0]  tick_r, tick_nxt;

  logic [dlc_pkg::TICK_W-1:0]  tick_inc;
  logic [dlc_pkg::FAIL_W-1:0]  fail_inc;
  logic [dlc_pkg::LIMIT_W-1:0] limit;
  logic                        timed_mode;
  logic                        pin_match;
  logic [dlc_pkg::EV_W-1:0]    ev;
  logic                        enter;
  logic [dlc_pkg::MODE_W-1:0]  enter_mode;

  assign tick_inc = (tick_r != dlc_pkg::TICK_MAX) ? tick_r + 1'b1 : tick_r;
  assign fail_inc = (fail_r != dlc_pkg::FAIL_MAX) ? fail_r + 1'b1 : fail_r;

  always_comb begin
    limit      = '0;
    timed_mode = 1'b1;
    case (mode_r)
      dlc_pkg::M_PIN:  limit = cfg.pin_timeout_ticks;
      dlc_pkg::M_OPEN: limit = cfg.unlock_ticks;
      dlc_pkg::M_DENY: limit = cfg.deny_ticks;
      dlc_pkg::M_LOCK: limit = cfg.lockout_ticks;
      default:         timed_mode = 1'b0;
    endcase
  end

  // keys with the incoming key placed at the current slot, then compared
  always_comb begin
    pin_match = 1'b1;
    for (int i = 0; i < dlc_pkg::PIN_DIGITS; i++) begin
      keys_wr[i] = (kcnt_r[dlc_pkg::KIDX_W-1:0] == dlc_pkg::KIDX_W'(i)) ? key_code
                                                                          : keys_r[i];
      pin_match  = pin_match & (keys_wr[i] == dlc_pkg::exp_key(cfg.pin_code, i));
    end
  end

  always_comb begin
    mode_nxt   = mode_r;
    keys_nxt   = keys_r;
    kcnt_nxt   = kcnt_r;
    fail_nxt   = fail_r;
    tick_nxt   = tick_r;
    ev         = dlc_pkg::EV_NONE;
    enter      = 1'b0;
    enter_mode = dlc_pkg::M_WAIT;

    case (cmd)
      dlc_pkg::CMD_TICK: begin
        tick_nxt = tick_inc;
        if (timed_mode && (tick_inc > {1'b0, limit})) begin
          if (mode_r == dlc_pkg::M_LOCK) begin
            fail_nxt = '0;
          end
          enter      = 1'b1;
          enter_mode = dlc_pkg::M_WAIT;
          ev         = dlc_pkg::EV_TIMED;
        end
      end
      dlc_pkg::CMD_CARD: begin
        if (mode_r == dlc_pkg::M_WAIT) begin
          enter = 1'b1;
          if (card_value == cfg.card_id) begin
            enter_mode = dlc_pkg::M_PIN;
            ev         = dlc_pkg::EV_CARD_OK;
          end else begin
            enter_mode = dlc_pkg::M_DENY;
            ev         = dlc_pkg::EV_CARD_BAD;
          end
        end
      end
      dlc_pkg::CMD_KEY: begin
        if (mode_r == dlc_pkg::M_PIN) begin
          tick_nxt = '0;
          if (kcnt_r < dlc_pkg::KCNT_W'(dlc_pkg::PIN_DIGITS)) begin
            keys_nxt = keys_wr;
            kcnt_nxt = kcnt_r + 1'b1;
            if (kcnt_r == dlc_pkg::KCNT_W'(dlc_pkg::PIN_DIGITS - 1)) begin
              enter = 1'b1;
              if (pin_match) begin
                enter_mode = dlc_pkg::M_OPEN;
                ev         = dlc_pkg::EV_PIN_OK;
              end else begin
                fail_nxt = fail_inc;
                if (fail_inc >= cfg.max_retries) begin
                  enter_mode = dlc_pkg::M_LOCK;
                  ev         = dlc_pkg::EV_LOCKOUT;
                end else begin
                  enter_mode = dlc_pkg::M_DENY;
                  ev         = dlc_pkg::EV_PIN_BAD;
                end
              end
            end
          end
        end
      end
      dlc_pkg::CMD_OPEN: begin
        enter      = 1'b1;
        enter_mode = dlc_pkg::M_OPEN;
      end
      dlc_pkg::CMD_CLOSE: begin
        enter      = 1'b1;
        enter_mode = dlc_pkg::M_WAIT;
      end
      dlc_pkg::CMD_LOCKOUT: begin
        enter      = 1'b1;
        enter_mode = dlc_pkg::M_LOCK;
        ev         = dlc_pkg::EV_LOCKOUT;
      end
      default: ;  // status and the unused code change nothing
    endcase

    // common mode entry: timer restarts, waiting/denied drop the keys,
    // unlocked forgives earlier failures
    if (enter) begin
      mode_nxt = enter_mode;
      tick_nxt = '0;
      if ((enter_mode == dlc_pkg::M_WAIT) || (enter_mode == dlc_pkg::M_DENY)) begin
        for (int i = 0; i < dlc_pkg::PIN_DIGITS; i++) begin
          keys_nxt[i] = '0;
        end
        kcnt_nxt = '0;
      end
      if (enter_mode == dlc_pkg::M_OPEN) begin
        fail_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= dlc_pkg::M_WAIT;
      kcnt_r <= '0;
      fail_r <= '0;
      tick_r <= '0;
      for (int i = 0; i < dlc_pkg::PIN_DIGITS; i++) begin
        keys_r[i] <= '0;
      end
    end else if (step) begin
      mode_r <= mode_nxt;
      kcnt_r <= kcnt_nxt;
      fail_r <= fail_nxt;
      tick_r <= tick_nxt;
      keys_r <= keys_nxt;
    end
  end

  always_comb begin
    res.mode           = mode_nxt;
    res.door_open      = (mode_nxt == dlc_pkg::M_OPEN);
    res.led_red        = (mode_nxt == dlc_pkg::M_DENY) || (mode_nxt == dlc_pkg::M_LOCK);
    res.led_green      = (mode_nxt == dlc_pkg::M_OPEN);
    res.led_blue       = (mode_nxt == dlc_pkg::M_PIN);
    res.digits_entered = dlc_pkg::DIGITS_W'(kcnt_nxt);
    res.failure_count  = fail_nxt;
    res.event_res      = ev;
  end

`ifndef SYNTHESIS
  a_kcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    kcnt_r <= dlc_pkg::KCNT_W'(dlc_pkg::PIN_DIGITS))
    else $error("key count beyond PIN length");

  a_pin_ok_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev == dlc_pkg::EV_PIN_OK) |=> (mode_r == dlc_pkg::M_OPEN) && (fail_r == '0))
    else $error("correct PIN did not unlock with failures cleared");

  a_deny_no_keys: assert property (@(posedge clk) disable iff (!rst_n)
    step && (mode_nxt == dlc_pkg::M_DENY) && (mode_r != dlc_pkg::M_DENY)
    |=> (kcnt_r == '0))
    else $error("keys kept on entry to denied");

  a_timed_wait: assert property (@(posedge clk) disable iff (!rst_n)
    step && (ev == dlc_pkg::EV_TIMED) |=> (mode_r == dlc_pkg::M_WAIT) && (tick_r == '0))
    else $error("timed return did not reach waiting with timer cleared");
`endif

endmodule

FILE: sv/card_and_pin_door_lock_controller_core.sv
// ----------------------------------------------------------------------------
// card_and_pin_door_lock_controller_core: card and PIN door lock controller
// Input register, single-pass lock state update and result register.
//
//   channel  dir  beat contents
//   in_      in   one request: tick, card, key or remote command
//   out_     out  one result per request: mode, lamps, counts, event
//   cfg_     in   register write, index 0..6, no read-back
//
// One request per cycle sustained while out_ is not stalled; the request passes
// the input register, then the result register, before its result is valid.
// Reset clears mode, keys, counts and timer, and loads register defaults.
// While out_ is stalled, one further request is held in the input register,
// after which in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module card_and_pin_door_lock_controller_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [dlc_pkg::IN_DATA_W-1:0]  in_tdata,   // card_value[39:0], key_code[47:40]
  input  logic [dlc_pkg::IN_USER_W-1:0]  in_tuser,   // cmd[2:0]
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // mode[2:0], door_open[3], led_red[4], led_green[5], led_blue[6],
  // digits_entered[9:7], failure_count[13:10], event_res[16:14], zero above
  output logic [dlc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_wr_en,
  input  logic [dlc_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [dlc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                        s1_valid_r, s1_valid_nxt;
  logic [dlc_pkg::CMD_W-1:0]   s1_cmd_r;
  logic [dlc_pkg::CARD_W-1:0]  s1_card_r;
  logic [dlc_pkg::KEY_W-1:0]   s1_key_r;
  logic                        out_valid_r, out_valid_nxt;
  dlc_pkg::res_t               out_res_r;

  dlc_pkg::cfg_t               cfg;
  dlc_pkg::res_t               res;
  logic                        in_acc;
  logic                        out_free;
  logic                        step;

  assign out_free  = !out_valid_r || out_tready;
  assign step      = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (step) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_cmd_r  <= in_tuser;
      s1_card_r <= in_tdata[dlc_pkg::CARD_W-1:0];
      s1_key_r  <= in_tdata[dlc_pkg::CARD_W +: dlc_pkg::KEY_W];
    end
    if (step) begin
      out_res_r <= res;
    end
  end

  dlc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dlc_fsm u_fsm (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd        (s1_cmd_r),
    .card_value (s1_card_r),
    .key_code   (s1_key_r),
    .cfg        (cfg),
    .res        (res)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(dlc_pkg::OUT_DATA_W - dlc_pkg::RES_W){1'b0}}, out_res_r};

`ifndef SYNTHESIS
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r)
    else $error("buffered request lost while result stalled");

  a_step_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("processed request produced no result");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready)
    else $error("request taken with both stages full");
`endif

endmodule

FILE: tb/sv/card_and_pin_door_lock_controller_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// card_and_pin_door_lock_controller_core_test: self-checking bench for the
// card and PIN door lock core
// A directed table (reset state, field extremes, every command, timed returns,
// right and wrong PIN) is followed by random phases of card/PIN sessions with
// noise, each phase under its own register set. Every result is checked field
// by field in request order against the table or an in-bench lock model.
// ----------------------------------------------------------------------------
module card_and_pin_door_lock_controller_core_test;
  import dlc_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;  // undefined command, ignored
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_REQS = 210;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [CARD_W-1:0] card;
    logic [KEY_W-1:0]  key;
    logic              typed;
    res_t              want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata;
  logic [IN_USER_W-1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // register mirror
  logic [PIN_W-1:0]   cf_pin;
  logic [CARD_W-1:0]  cf_card;
  logic [RETRY_W-1:0] cf_retries;
  logic [LIMIT_W-1:0] cf_t_pin;
  logic [LIMIT_W-1:0] cf_t_unlock;
  logic [LIMIT_W-1:0] cf_t_deny;
  logic [LIMIT_W-1:0] cf_t_lock;

  // lock state as the model sees it
  logic [MODE_W-1:0] lk_mode;
  logic [KEY_W-1:0]  lk_keys [PIN_DIGITS];
  int unsigned       lk_nkeys;
  logic [FAIL_W-1:0] lk_fails;
  logic [TICK_W-1:0] lk_ticks;
  bit                lk_ignored;

  res_t      owed_results [$];
  stim_row_t script [$];
  bit        idle_on;
  int        fed;
  int        faults;
  int        n_results;
  res_t      seen;
  res_t      owed;

  card_and_pin_door_lock_controller_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // card_value[39:0], key_code[47:40]
    .in_tuser   (in_tuser),   // cmd[2:0]
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    // mode[2:0], door_open[3], led_red[4], led_green[5], led_blue[6],
    // digits_entered[9:7], failure_count[13:10], event_res[16:14]
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("Mismatches found");
    $finish;
  end

  // ---------------------------------------------------------------- model

  function automatic logic [KEY_W-1:0] pin_byte(input int unsigned i);
    int unsigned pos;
    logic [PIN_W-1:0] sh;
    pos = PIN_DIGITS - 1 - i;
    sh  = (pos < PIN_W / KEY_W) ? (cf_pin >> (KEY_W * pos)) : '0;
    return sh[KEY_W-1:0];
  endfunction

  function automatic void go_mode(input logic [MODE_W-1:0] m);
    lk_mode  = m;
    lk_ticks = '0;
    if (m == M_WAIT || m == M_DENY) begin
      foreach (lk_keys[i]) lk_keys[i] = '0;
      lk_nkeys = 0;
    end
    if (m == M_OPEN) lk_fails = '0;
  endfunction

  function automatic res_t door_lock_next(input logic [CMD_W-1:0] cmd,
                                          input logic [CARD_W-1:0] card,
                                          input logic [KEY_W-1:0] key);
    logic [EV_W-1:0]    ev;
    logic [LIMIT_W-1:0] limit;
    bit                 match;
    res_t               r;
    ev = EV_NONE;
    lk_ignored = 1'b0;
    case (cmd)
      CMD_TICK: begin
        if (lk_ticks != TICK_MAX) lk_ticks = lk_ticks + 25'd1;
        case (lk_mode)
          M_PIN:   limit = cf_t_pin;
          M_OPEN:  limit = cf_t_unlock;
          M_DENY:  limit = cf_t_deny;
          M_LOCK:  limit = cf_t_lock;
          default: limit = '1;
        endcase
        if (lk_mode != M_WAIT && lk_ticks > {1'b0, limit}) begin
          if (lk_mode == M_LOCK) lk_fails = '0;
          go_mode(M_WAIT);
          ev = EV_TIMED;
        end
      end
      CMD_CARD: begin
        if (lk_mode != M_WAIT) begin
          lk_ignored = 1'b1;
        end else if (card == cf_card) begin
          go_mode(M_PIN);
          ev = EV_CARD_OK;
        end else begin
          go_mode(M_DENY);
          ev = EV_CARD_BAD;
        end
      end
      CMD_KEY: begin
        if (lk_mode != M_PIN) begin
          lk_ignored = 1'b1;
        end else begin
          lk_ticks = '0;
          if (lk_nkeys < PIN_DIGITS) begin
            lk_keys[lk_nkeys] = key;
            lk_nkeys++;
            if (lk_nkeys == PIN_DIGITS) begin
              match = 1'b1;
              for (int i = 0; i < PIN_DIGITS; i++) begin
                if (lk_keys[i] != pin_byte(i)) match = 1'b0;
              end
              if (match) begin
                go_mode(M_OPEN);
                ev = EV_PIN_OK;
              end else begin
                if (lk_fails != FAIL_MAX) lk_fails = lk_fails + 4'd1;
                if (lk_fails >= cf_retries) begin
                  go_mode(M_LOCK);
                  ev = EV_LOCKOUT;
                end else begin
                  go_mode(M_DENY);
                  ev = EV_PIN_BAD;
                end
              end
            end
          end
        end
      end
      CMD_OPEN:  go_mode(M_OPEN);
      CMD_CLOSE: go_mode(M_WAIT);
      CMD_LOCKOUT: begin
        go_mode(M_LOCK);
        ev = EV_LOCKOUT;
      end
      default: lk_ignored = 1'b1;
    endcase
    r.mode           = lk_mode;
    r.door_open      = (lk_mode == M_OPEN);
    r.led_red        = (lk_mode == M_DENY || lk_mode == M_LOCK);
    r.led_green      = (lk_mode == M_OPEN);
    r.led_blue       = (lk_mode == M_PIN);
    r.digits_entered = lk_nkeys[DIGITS_W-1:0];
    r.failure_count  = lk_fails;
    r.event_res      = ev;
    return r;
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic flag(input string what, input logic [63:0] exp, input logic [63:0] act);
    faults++;
    if (faults <= 10)
      $display("ERROR result %0d %s: expected %0h, got %0h", n_results, what, exp, act);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (owed_results.size() == 0) begin
        flag("arrived with nothing pending", '0, out_tdata);
      end else begin
        owed = owed_results.pop_front();
        seen = out_tdata[RES_W-1:0];
        if (seen.mode !== owed.mode) flag("mode", owed.mode, seen.mode);
        if (seen.door_open !== owed.door_open) flag("door_open", owed.door_open, seen.door_open);
        if (seen.led_red !== owed.led_red) flag("led_red", owed.led_red, seen.led_red);
        if (seen.led_green !== owed.led_green) flag("led_green", owed.led_green, seen.led_green);
        if (seen.led_blue !== owed.led_blue) flag("led_blue", owed.led_blue, seen.led_blue);
        if (seen.digits_entered !== owed.digits_entered)
          flag("digits_entered", owed.digits_entered, seen.digits_entered);
        if (seen.failure_count !== owed.failure_count)
          flag("failure_count", owed.failure_count, seen.failure_count);
        if (seen.event_res !== owed.event_res) flag("event_res", owed.event_res, seen.event_res);
        if (out_tdata[OUT_DATA_W-1:RES_W] !== '0)
          flag("padding", '0, out_tdata[OUT_DATA_W-1:RES_W]);
      end
      n_results++;
    end
  end

  // result side back-pressure, in bursts
  initial begin
    out_tready <= 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 12)) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic logic [CARD_W-1:0] rand_card();
    return {8'($urandom), $urandom()};
  endfunction

  function automatic logic [KEY_W-1:0] rand_key();
    return 8'($urandom);
  endfunction

  function automatic res_t shown(input logic [MODE_W-1:0] m, input logic door,
                                 input logic red, input logic green, input logic blue,
                                 input logic [DIGITS_W-1:0] digits,
                                 input logic [FAIL_W-1:0] fails, input logic [EV_W-1:0] ev);
    res_t r;
    r.mode           = m;
    r.door_open      = door;
    r.led_red        = red;
    r.led_green      = green;
    r.led_blue       = blue;
    r.digits_entered = digits;
    r.failure_count  = fails;
    r.event_res      = ev;
    return r;
  endfunction

  function automatic stim_row_t row(input logic [CMD_W-1:0] c, input logic [CARD_W-1:0] cd,
                                    input logic [KEY_W-1:0] k, input logic t, input res_t w);
    stim_row_t s;
    s.cmd   = c;
    s.card  = cd;
    s.key   = k;
    s.typed = t;
    s.want  = w;
    return s;
  endfunction

  task automatic put_item(input logic [CMD_W-1:0] cmd, input logic [CARD_W-1:0] card,
                          input logic [KEY_W-1:0] key, input logic typed = 1'b0,
                          input res_t want = '0);
    res_t calc;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {key, card};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    calc = door_lock_next(cmd, card, key);
    owed_results.push_back(typed ? want : calc);
    if (!lk_ignored) fed++;
  endtask

  // hold off the sender until every pending result is back or the wait limit runs out
  task automatic settle();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_PIN_CODE:    cf_pin      = val[PIN_W-1:0];
      REG_CARD_ID:     cf_card     = val[CARD_W-1:0];
      REG_MAX_RETRIES: cf_retries  = val[RETRY_W-1:0];
      REG_PIN_TIMEOUT: cf_t_pin    = val[LIMIT_W-1:0];
      REG_UNLOCK:      cf_t_unlock = val[LIMIT_W-1:0];
      REG_DENY:        cf_t_deny   = val[LIMIT_W-1:0];
      REG_LOCKOUT:     cf_t_lock   = val[LIMIT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input logic [PIN_W-1:0] pin, input logic [CARD_W-1:0] card,
                           input logic [RETRY_W-1:0] retries, input logic [LIMIT_W-1:0] tp,
                           input logic [LIMIT_W-1:0] tu, input logic [LIMIT_W-1:0] td,
                           input logic [LIMIT_W-1:0] tl);
    set_reg(REG_PIN_CODE, {8'd0, pin});
    set_reg(REG_CARD_ID, card);
    set_reg(REG_MAX_RETRIES, {36'd0, retries});
    set_reg(REG_PIN_TIMEOUT, {16'd0, tp});
    set_reg(REG_UNLOCK, {16'd0, tu});
    set_reg(REG_DENY, {16'd0, td});
    set_reg(REG_LOCKOUT, {16'd0, tl});
  endtask

  task automatic remote_any();
    case ($urandom_range(0, 2))
      0:       put_item(CMD_OPEN, rand_card(), rand_key());
      1:       put_item(CMD_LOCKOUT, rand_card(), rand_key());
      default: put_item(CMD_STATUS, rand_card(), rand_key());
    endcase
  endtask

  // one card + PIN attempt, or a way back to waiting, or noise
  task automatic walk_session(input int good_pct);
    int r;
    int nk;
    int spoil;
    logic [KEY_W-1:0] code [PIN_DIGITS];
    r = $urandom_range(0, 99);
    if (lk_mode != M_WAIT) begin
      if (r < 25) put_item(CMD_CLOSE, rand_card(), rand_key());
      else if (r < 32) remote_any();
      else repeat ($urandom_range(1, 20)) put_item(CMD_TICK, rand_card(), rand_key());
    end else if (r < 8) begin
      put_item(3'($urandom_range(0, 7)), rand_card(), rand_key());
    end else if (r < 12) begin
      remote_any();
    end else begin
      put_item(CMD_CARD, ($urandom_range(0, 99) < 85) ? cf_card : rand_card(), rand_key());
      for (int i = 0; i < PIN_DIGITS; i++) code[i] = pin_byte(i);
      if ($urandom_range(0, 99) >= good_pct) begin
        if ($urandom_range(0, 3) == 0) begin
          foreach (code[i]) code[i] = rand_key();
        end else begin
          spoil = $urandom_range(0, PIN_DIGITS - 1);
          code[spoil] = code[spoil] ^ 8'($urandom_range(1, 255));
        end
      end
      case ($urandom_range(0, 19))
        0:       nk = PIN_DIGITS - 1;   // leave entry hanging for the timeout
        1:       nk = PIN_DIGITS + 1;   // stray key after the compare
        default: nk = PIN_DIGITS;
      endcase
      for (int i = 0; i < nk; i++) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 3)) put_item(CMD_TICK, rand_card(), rand_key());
        put_item(CMD_KEY, rand_card(), (i < PIN_DIGITS) ? code[i] : rand_key());
      end
    end
    repeat ($urandom_range(0, 6)) put_item(CMD_TICK, rand_card(), rand_key());
  endtask

  // ---------------------------------------------------------------- run

  initial begin
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= CMD_STATUS;
    cfg_wr_en <= 1'b0;
    cfg_addr  <= REG_PIN_CODE;
    cfg_wdata <= '0;
    idle_on     = 1'b1;
    fed         = 0;
    faults      = 0;
    n_results   = 0;
    cf_pin      = RST_PIN_CODE;
    cf_card     = RST_CARD_ID;
    cf_retries  = RST_MAX_RETRIES;
    cf_t_pin    = RST_PIN_TIMEOUT;
    cf_t_unlock = RST_UNLOCK;
    cf_t_deny   = RST_DENY;
    cf_t_lock   = RST_LOCKOUT;
    lk_mode     = M_WAIT;
    foreach (lk_keys[i]) lk_keys[i] = '0;
    lk_nkeys    = 0;
    lk_fails    = '0;
    lk_ticks    = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // short limits so timed returns show up in the table
    set_reg(REG_MAX_RETRIES, 40'd2);
    set_reg(REG_PIN_TIMEOUT, 40'd1);
    set_reg(REG_UNLOCK, 40'd0);
    set_reg(REG_DENY, 40'd0);
    set_reg(REG_LOCKOUT, 40'd1);

    script.push_back(row(CMD_STATUS, '0, '0, 1'b1,
                         shown(M_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0, EV_NONE)));
    script.push_back(row(CMD_KEY, '0, 8'hFF, 1'b1,
                         shown(M_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0, EV_NONE)));
    script.push_back(row(CMD_TICK, '0, '0, 1'b1,
                         shown(M_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0, EV_NONE)));
    script.push_back(row(CMD_CARD, '1, '0, 1'b1,
                         shown(M_DENY, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 4'd0, EV_CARD_BAD)));
    script.push_back(row(CMD_CARD, RST_CARD_ID, '0, 1'b0, '0));  // card while denied
    script.push_back(row(CMD_TICK, '0, '0, 1'b1,
                         shown(M_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0, EV_TIMED)));
    script.push_back(row(CMD_CARD, RST_CARD_ID, '0, 1'b1,
                         shown(M_PIN, 1'b0, 1'b0, 1'b0, 1'b1, 3'd0, 4'd0, EV_CARD_OK)));
    script.push_back(row(CMD_KEY, '0, 8'h00, 1'b0, '0));
    script.push_back(row(CMD_TICK, '0, '0, 1'b0, '0));
    script.push_back(row(CMD_TICK, '0, '0, 1'b1,
                         shown(M_WAIT, 1'b0, 1'b0, 1'b0, 1'b0, 3'd0, 4'd0, EV_TIMED)));
    script.push_back(row(CMD_CARD, RST_CARD_ID, '0, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h31, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h32, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h33, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h34, 1'b1,
                         shown(M_OPEN, 1'b1, 1'b0, 1'b1, 1'b0, 3'd4, 4'd0, EV_PIN_OK)));
    script.push_back(row(CMD_CLOSE, '0, '0, 1'b0, '0));
    script.push_back(row(CMD_CARD, RST_CARD_ID, '0, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'hFF, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h80, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h7F, 1'b0, '0));
    script.push_back(row(CMD_KEY, '0, 8'h00, 1'b1,
                         shown(M_DENY, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 4'd1, EV_PIN_BAD)));
    script.push_back(row(CMD_LOCKOUT, '0, '0, 1'b1,
                         shown(M_LOCK, 1'b0, 1'b1, 1'b0, 1'b0, 3'd0, 4'd1, EV_LOCKOUT)));
    script.push_back(row(CMD_OPEN, '0, '0, 1'b0, '0));
    script.push_back(row(CMD_SPARE, '1, 8'hFF, 1'b0, '0));
    script.push_back(row(CMD_CLOSE, '1, 8'hFF, 1'b0, '0));
    foreach (script[i]) put_item(script[i].cmd, script[i].card, script[i].key,
                                 script[i].typed, script[i].want);

    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      case (ph)
        0: load_regs(RST_PIN_CODE, RST_CARD_ID, RST_MAX_RETRIES, RST_PIN_TIMEOUT,
                     RST_UNLOCK, RST_DENY, RST_LOCKOUT);
        1: load_regs('0, '0, 4'd1, '0, '0, '0, '0);
        2: load_regs('1, '1, 4'd15, '1, '1, '1, '1);
        default: load_regs($urandom(), rand_card(), 4'($urandom_range(1, 15)),
                           24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)),
                           24'($urandom_range(0, 12)), 24'($urandom_range(0, 12)));
      endcase
      idle_on = (ph != 5 && ph != PHASES - 1);
      fed = 0;
      // mostly wrong PINs under the high extremes, to push the failure count up
      while (fed < PHASE_REQS) walk_session((ph == 2) ? 10 : 50);
    end

    settle();
    if (owed_results.size() != 0) flag("results never produced", owed_results.size(), '0);
    if (faults == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
